// ----- sv/lfu_pkg.sv -----
// Shared constants and types for the LFU replacement table.
package lfu_pkg;

    // Default sizes of the table.
    localparam int LFU_ENTRIES     = 8;
    localparam int LFU_KEY_WIDTH   = 16;
    localparam int LFU_COUNT_WIDTH = 16;
    localparam int LFU_MISS_WIDTH  = 32;

    // Control flags of the scan item that walks the cell chain.
    typedef struct packed {
        logic tv;     // a scan item is present at this position
        logic hit;    // a valid entry with the same key was found
        logic empty;  // an empty entry was found
    } t_scan_ctl;

endpackage

// ----- sv/lfu_req_if.sv -----
// Request channel: valid/ready handshake carrying one lookup key.
interface lfu_req_if #(
    parameter int KEY_WIDTH = lfu_pkg::LFU_KEY_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic [KEY_WIDTH-1:0] request_key;

    modport source (output valid, output request_key, input ready);
    modport sink   (input valid, input request_key, output ready);
endinterface

// ----- sv/lfu_res_if.sv -----
// Result channel: valid/ready handshake carrying one lookup result.
interface lfu_res_if #(
    parameter int COUNT_WIDTH = lfu_pkg::LFU_COUNT_WIDTH,
    parameter int SLOT_WIDTH  = 3
);
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic [SLOT_WIDTH-1:0]              slot;
    logic [COUNT_WIDTH-1:0]             use_count;
    logic                               filled_empty;
    logic                               evicted;
    logic [lfu_pkg::LFU_MISS_WIDTH-1:0] miss_count;

    modport source (output valid, output hit, output slot, output use_count,
                    output filled_empty, output evicted, output miss_count,
                    input ready);
    modport sink   (input valid, input hit, input slot, input use_count,
                    input filled_empty, input evicted, input miss_count,
                    output ready);
endinterface

// ----- sv/lfu_replacement_table_top.sv -----
// A request is taken only while idle: it walks the cell chain one cell per cycle,
// then the chosen entry is written and the result registered; a new request is taken
// only once that result has moved into the output register.
// A waiting result is held in the output register while the next request is taken.
// Reset (synchronous, active low) clears all valid bits, use counts and the eviction
// counter at once; no clearing pass is needed.
module lfu_replacement_table_top #(
    parameter int ENTRIES     = lfu_pkg::LFU_ENTRIES,
    parameter int KEY_WIDTH   = lfu_pkg::LFU_KEY_WIDTH,
    parameter int COUNT_WIDTH = lfu_pkg::LFU_COUNT_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lfu_req_if.sink    i_req,
    lfu_res_if.source  o_res
);
    import lfu_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;

    // Chain links: position k feeds cell k, position ENTRIES is the chain's end.
    t_scan_ctl              w_ctl       [ENTRIES+1];
    logic [KEY_WIDTH-1:0]   w_key       [ENTRIES+1];
    logic [IDX_W-1:0]       w_hit_idx   [ENTRIES+1];
    logic [COUNT_WIDTH-1:0] w_hit_cnt   [ENTRIES+1];
    logic [IDX_W-1:0]       w_empty_idx [ENTRIES+1];
    logic [COUNT_WIDTH-1:0] w_min_cnt   [ENTRIES+1];
    logic [IDX_W-1:0]       w_min_idx   [ENTRIES+1];
    logic [ENTRIES-1:0]     w_tv_vec;

    logic                   w_accept;
    logic                   w_done;
    logic                   w_evict;
    logic                   w_fill;
    logic [IDX_W-1:0]       w_slot;
    logic [COUNT_WIDTH-1:0] w_count;

    logic [LFU_MISS_WIDTH-1:0] r_miss_count, n_miss_count;

    // Finished result waiting for the output register.
    logic                      r_res_hit;
    logic [IDX_W-1:0]          r_res_slot;
    logic [COUNT_WIDTH-1:0]    r_res_count;
    logic                      r_res_fill;
    logic                      r_res_evict;
    logic [LFU_MISS_WIDTH-1:0] r_res_miss;

    // Output register.
    logic                      r_o_valid;
    logic                      r_o_hit;
    logic [IDX_W-1:0]          r_o_slot;
    logic [COUNT_WIDTH-1:0]    r_o_count;
    logic                      r_o_fill;
    logic                      r_o_evict;
    logic [LFU_MISS_WIDTH-1:0] r_o_miss;
    logic                      w_o_load;

    // Requests enter only when the chain is free.
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // Launch the scan item into the first cell; the minimum starts at the top value.
    assign w_ctl[0]       = '{tv: w_accept, hit: 1'b0, empty: 1'b0};
    assign w_key[0]       = i_req.request_key;
    assign w_hit_idx[0]   = '0;
    assign w_hit_cnt[0]   = '0;
    assign w_empty_idx[0] = '0;
    assign w_min_cnt[0]   = '1;
    assign w_min_idx[0]   = '0;

    // The row of entry cells.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .COUNT_WIDTH (COUNT_WIDTH),
            .IDX_W       (IDX_W),
            .INDEX       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl[g]),
            .i_key       (w_key[g]),
            .i_hit_idx   (w_hit_idx[g]),
            .i_hit_cnt   (w_hit_cnt[g]),
            .i_empty_idx (w_empty_idx[g]),
            .i_min_cnt   (w_min_cnt[g]),
            .i_min_idx   (w_min_idx[g]),
            .o_ctl       (w_ctl[g+1]),
            .o_key       (w_key[g+1]),
            .o_hit_idx   (w_hit_idx[g+1]),
            .o_hit_cnt   (w_hit_cnt[g+1]),
            .o_empty_idx (w_empty_idx[g+1]),
            .o_min_cnt   (w_min_cnt[g+1]),
            .o_min_idx   (w_min_idx[g+1]),
            .i_upd_en    (w_done),
            .i_upd_idx   (w_slot),
            .i_upd_key   (w_key[ENTRIES]),
            .i_upd_count (w_count)
        );
        assign w_tv_vec[g] = w_ctl[g+1].tv;
    end

    // Decision at the end of the chain: hit, else first empty entry, else lowest count.
    assign w_done = (r_state == S_SCAN) && w_ctl[ENTRIES].tv;

    always_comb begin
        w_evict = 1'b0;
        w_fill  = 1'b0;
        if (w_ctl[ENTRIES].hit) begin
            w_slot  = w_hit_idx[ENTRIES];
            w_count = (w_hit_cnt[ENTRIES] == '1) ? w_hit_cnt[ENTRIES]
                                                 : w_hit_cnt[ENTRIES] + 1'b1;
        end else if (w_ctl[ENTRIES].empty) begin
            w_slot  = w_empty_idx[ENTRIES];
            w_count = COUNT_WIDTH'(1);
            w_fill  = 1'b1;
        end else begin
            w_slot  = w_min_idx[ENTRIES];
            w_count = COUNT_WIDTH'(1);
            w_evict = 1'b1;
        end
    end

    // Saturating eviction counter.
    always_comb begin
        n_miss_count = r_miss_count;
        if (w_done && w_evict && (r_miss_count != '1)) begin
            n_miss_count = r_miss_count + 1'b1;
        end
    end

    // Sequencer: idle, scanning, result waiting for the output register.
    assign w_o_load = (r_state == S_DONE) && (!r_o_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_SCAN;
            S_SCAN:  if (w_done) n_state = S_DONE;
            S_DONE:  if (w_o_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_miss_count <= '0;
        end else begin
            r_state      <= n_state;
            r_miss_count <= n_miss_count;
        end
    end

    // Capture the finished result.
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_res_hit   <= w_ctl[ENTRIES].hit;
            r_res_slot  <= w_slot;
            r_res_count <= w_count;
            r_res_fill  <= w_fill;
            r_res_evict <= w_evict;
            r_res_miss  <= n_miss_count;
        end
    end

    // Output register and its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_load) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_load) begin
            r_o_hit   <= r_res_hit;
            r_o_slot  <= r_res_slot;
            r_o_count <= r_res_count;
            r_o_fill  <= r_res_fill;
            r_o_evict <= r_res_evict;
            r_o_miss  <= r_res_miss;
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.hit          = r_o_hit;
    assign o_res.slot         = r_o_slot;
    assign o_res.use_count    = r_o_count;
    assign o_res.filled_empty = r_o_fill;
    assign o_res.evicted      = r_o_evict;
    assign o_res.miss_count   = r_o_miss;

`ifndef SYNTHESIS
    // At most one scan item is in the chain at any time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tv_vec))
        else $error("more than one scan item in the cell chain");

    // The scan item reaches the end of the chain only while scanning.
    a_end_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[ENTRIES].tv |-> (r_state == S_SCAN))
        else $error("scan item at chain end outside the scan state");

    // A result is at most one of hit, fill and eviction, and exactly one of them.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> $onehot({r_o_hit, r_o_fill, r_o_evict}))
        else $error("result kind flags are not exclusive");

    // The eviction counter never falls.
    a_miss_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_miss_count >= $past(r_miss_count)))
        else $error("eviction counter decreased");
`endif

endmodule

// ----- sv/lfu_cell.sv -----
// One table entry: holds key, valid bit and use count, and folds its state into the scan item.
module lfu_cell #(
    parameter int KEY_WIDTH   = 16,
    parameter int COUNT_WIDTH = 16,
    parameter int IDX_W       = 3,
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Scan item from the left neighbor.
    input  lfu_pkg::t_scan_ctl     i_ctl,
    input  logic [KEY_WIDTH-1:0]   i_key,
    input  logic [IDX_W-1:0]       i_hit_idx,
    input  logic [COUNT_WIDTH-1:0] i_hit_cnt,
    input  logic [IDX_W-1:0]       i_empty_idx,
    input  logic [COUNT_WIDTH-1:0] i_min_cnt,
    input  logic [IDX_W-1:0]       i_min_idx,
    // Scan item to the right neighbor.
    output lfu_pkg::t_scan_ctl     o_ctl,
    output logic [KEY_WIDTH-1:0]   o_key,
    output logic [IDX_W-1:0]       o_hit_idx,
    output logic [COUNT_WIDTH-1:0] o_hit_cnt,
    output logic [IDX_W-1:0]       o_empty_idx,
    output logic [COUNT_WIDTH-1:0] o_min_cnt,
    output logic [IDX_W-1:0]       o_min_idx,
    // Entry write broadcast at the end of a scan.
    input  logic                   i_upd_en,
    input  logic [IDX_W-1:0]       i_upd_idx,
    input  logic [KEY_WIDTH-1:0]   i_upd_key,
    input  logic [COUNT_WIDTH-1:0] i_upd_count
);
    import lfu_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    // Entry state.
    logic                   r_valid;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [COUNT_WIDTH-1:0] r_count;

    // Registered scan item and its next value.
    t_scan_ctl              r_ctl,       n_ctl;
    logic [KEY_WIDTH-1:0]   r_skey;
    logic [IDX_W-1:0]       r_hit_idx,   n_hit_idx;
    logic [COUNT_WIDTH-1:0] r_hit_cnt,   n_hit_cnt;
    logic [IDX_W-1:0]       r_empty_idx, n_empty_idx;
    logic [COUNT_WIDTH-1:0] r_min_cnt,   n_min_cnt;
    logic [IDX_W-1:0]       r_min_idx,   n_min_idx;

    // Fold this entry into the scan: first match, first empty, strict lowest count.
    always_comb begin
        n_ctl       = i_ctl;
        n_hit_idx   = i_hit_idx;
        n_hit_cnt   = i_hit_cnt;
        n_empty_idx = i_empty_idx;
        n_min_cnt   = i_min_cnt;
        n_min_idx   = i_min_idx;
        if (!i_ctl.hit && r_valid && (r_key == i_key)) begin
            n_ctl.hit = 1'b1;
            n_hit_idx = MY_IDX;
            n_hit_cnt = r_count;
        end
        if (!i_ctl.empty && !r_valid) begin
            n_ctl.empty = 1'b1;
            n_empty_idx = MY_IDX;
        end
        if (r_count < i_min_cnt) begin
            n_min_cnt = r_count;
            n_min_idx = MY_IDX;
        end
    end

    // Scan item register: only the presence flag needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_skey      <= i_key;
        r_hit_idx   <= n_hit_idx;
        r_hit_cnt   <= n_hit_cnt;
        r_empty_idx <= n_empty_idx;
        r_min_cnt   <= n_min_cnt;
        r_min_idx   <= n_min_idx;
    end

    // Entry write at the end of every scan (hit, fill or eviction); the key needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else if (i_upd_en && (i_upd_idx == MY_IDX)) begin
            r_valid <= 1'b1;
            r_count <= i_upd_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd_en && (i_upd_idx == MY_IDX)) begin
            r_key <= i_upd_key;
        end
    end

    assign o_ctl       = r_ctl;
    assign o_key       = r_skey;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_cnt   = r_hit_cnt;
    assign o_empty_idx = r_empty_idx;
    assign o_min_cnt   = r_min_cnt;
    assign o_min_idx   = r_min_idx;

endmodule
